// ===== design/tilt_pkg.sv =====
// Shared types, constants and the CORDIC angle table for the tilt-angle block.
package tilt_pkg;

   // Internal magnitudes are sized for the widest sample the block supports.
   localparam int MAX_SAMPLE_BITS = 24;
   localparam int GUARD_BITS      = 8;
   localparam int CORDIC_STEPS    = 24;
   localparam int ATAN_FRAC       = 24;
   localparam int OUT_BITS        = 16;

   // A magnitude with guard bits: up to 2^(S-1) * sqrt(2) * 2^G.
   localparam int MAG_BITS   = MAX_SAMPLE_BITS + GUARD_BITS + 1;
   // Sum of two squares with guard bits.
   localparam int SQ_BITS    = 2 * MAG_BITS;
   // CORDIC datapath; X can grow by about 1.65x.
   localparam int CW         = MAG_BITS + 3;
   localparam int ACC_BITS   = 32;

   typedef logic [MAG_BITS-1:0]        mag_type;
   typedef logic [SQ_BITS-1:0]         sq_type;
   typedef logic signed [CW-1:0]       cw_type;
   typedef logic signed [ACC_BITS-1:0] acc_type;

   // atan(2^-i) in degrees * 2^24.
   function automatic acc_type atan_tab(input logic [4:0] i);
      acc_type v;
      case (i)
         5'd0:  v = 32'sd754974720;
         5'd1:  v = 32'sd445687602;
         5'd2:  v = 32'sd235489088;
         5'd3:  v = 32'sd119537938;
         5'd4:  v = 32'sd60000934;
         5'd5:  v = 32'sd30029717;
         5'd6:  v = 32'sd15018523;
         5'd7:  v = 32'sd7509720;
         5'd8:  v = 32'sd3754917;
         5'd9:  v = 32'sd1877466;
         5'd10: v = 32'sd938734;
         5'd11: v = 32'sd469367;
         5'd12: v = 32'sd234684;
         5'd13: v = 32'sd117342;
         5'd14: v = 32'sd58671;
         5'd15: v = 32'sd29335;
         5'd16: v = 32'sd14668;
         5'd17: v = 32'sd7334;
         5'd18: v = 32'sd3667;
         5'd19: v = 32'sd1833;
         5'd20: v = 32'sd917;
         5'd21: v = 32'sd458;
         5'd22: v = 32'sd229;
         5'd23: v = 32'sd115;
         default: v = '0;
      endcase
      return v;
   endfunction

   // Per-lane flags that ride along the pipeline.
   typedef struct packed {
      logic neg;      // result is negated
      logic num_zero; // numerator is zero -> 0
      logic den_zero; // denominator is zero -> 90 deg
   } lane_flags_type;

endpackage

// ===== design/tilt_if.sv =====
// Valid/ready stream interface carrying a payload of type T.
interface tilt_if #(parameter type T = logic) (input logic clock);
   logic valid;
   logic ready;
   T     data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== design/accel_tilt_angles.sv =====
// Top level: accelerometer sample in, three tilt angles out, fully pipelined.
//
// req channel (tilt_if sink): accel_x/y/z, signed samples; only the low
// SAMPLE_BITS bits count. rsp channel (tilt_if source): tilt_x/y/z in degrees
// times 2^ANGLE_FRAC_BITS, two's complement, plus zero_vector for an all-zero
// sample (angles then read 0).
// Pipeline: 1 input stage + 2 square/sum stages + SQ_BITS/2 root stages
// (33, sized for the widest supported sample) + 24 CORDIC stages + 1 output
// stage between the req transfer and rsp_valid.
// Throughput: one transfer per cycle while the pipe is not frozen; the three
// lanes run side by side, each with its own square-root and CORDIC pipeline.
// Stall: the whole pipeline advances on one enable. When the receiver holds
// off and the last stage holds a valid result, the pipe freezes; nothing is
// lost or repeated. req_ready drops while the pipe is frozen or in reset.
// Reset (synchronous, active high) clears the valid bits; payload registers
// keep whatever they held and are never presented without a valid.
module accel_tilt_angles
   import tilt_pkg::*;
#(
   parameter int SAMPLE_BITS     = 16,
   parameter int ANGLE_FRAC_BITS = 8
) (
   input  logic clock,
   input  logic reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_accel_x,
   input  logic [15:0] req_accel_y,
   input  logic [15:0] req_accel_z,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_tilt_x,
   output logic [15:0] rsp_tilt_y,
   output logic [15:0] rsp_tilt_z,
   output logic        rsp_zero_vector
);
   localparam int SQ_STEPS = SQ_BITS / 2;
   // input reg + squares + sum + root + CORDIC + output reg
   localparam int DEPTH = 1 + 2 + SQ_STEPS + CORDIC_STEPS + 1;
   localparam int SB = SAMPLE_BITS;

   logic enable;
   logic [DEPTH-1:0] valid_ff, valid_in;

   // Freeze only when the last stage holds an untaken result.
   assign enable    = !(valid_ff[DEPTH-1] && !rsp_ready);
   assign req_ready = enable && !reset;

   always_comb begin
      valid_in = {valid_ff[DEPTH-2:0], req_valid};
   end
   always_ff @(posedge clock) begin
      if (reset)       valid_ff <= '0;
      else if (enable) valid_ff <= valid_in;
   end

   // Input stage: take the low SB bits (zero-extended past 16), magnitudes and signs.
   logic signed [SB-1:0] sx, sy, sz;
   logic [SB-1:0] ax_ff, ay_ff, az_ff;
   logic nx_ff, ny_ff, nz_ff, zero_ff;
   always_comb begin
      sx = SB'(req_accel_x);
      sy = SB'(req_accel_y);
      sz = SB'(req_accel_z);
   end
   always_ff @(posedge clock) begin
      if (enable) begin
         ax_ff   <= sx[SB-1] ? SB'(-sx) : SB'(sx);
         ay_ff   <= sy[SB-1] ? SB'(-sy) : SB'(sy);
         az_ff   <= sz[SB-1] ? SB'(-sz) : SB'(sz);
         nx_ff   <= !sx[SB-1] && (sx != '0); // tilt_x negative when x > 0
         ny_ff   <= sy[SB-1];
         nz_ff   <= sz[SB-1];
         zero_ff <= (sx == '0) && (sy == '0) && (sz == '0);
      end
   end

   logic [OUT_BITS-1:0] ang_x, ang_y, ang_z;

   tilt_lane #(.SAMPLE_BITS(SB), .FRAC(ANGLE_FRAC_BITS), .ROOT_ON_NUM(1'b0)) u_lane_x (
      .clock(clock), .enable(enable), .plain_mag(ax_ff), .root_mag_a(ay_ff),
      .root_mag_b(az_ff), .neg(nx_ff), .angle(ang_x));
   tilt_lane #(.SAMPLE_BITS(SB), .FRAC(ANGLE_FRAC_BITS), .ROOT_ON_NUM(1'b0)) u_lane_y (
      .clock(clock), .enable(enable), .plain_mag(ay_ff), .root_mag_a(ax_ff),
      .root_mag_b(az_ff), .neg(ny_ff), .angle(ang_y));
   tilt_lane #(.SAMPLE_BITS(SB), .FRAC(ANGLE_FRAC_BITS), .ROOT_ON_NUM(1'b1)) u_lane_z (
      .clock(clock), .enable(enable), .plain_mag(az_ff), .root_mag_a(ax_ff),
      .root_mag_b(ay_ff), .neg(nz_ff), .angle(ang_z));

   // Zero-vector flag delayed to line up with the lane outputs.
   localparam int ZD = DEPTH - 1;
   logic [ZD-1:0] zero_d_ff;
   always_ff @(posedge clock) begin
      if (enable) zero_d_ff <= {zero_d_ff[ZD-2:0], zero_ff};
   end

   assign rsp_valid       = valid_ff[DEPTH-1];
   assign rsp_tilt_x      = ang_x;
   assign rsp_tilt_y      = ang_y;
   assign rsp_tilt_z      = ang_z;
   assign rsp_zero_vector = zero_d_ff[ZD-1];
endmodule

// ===== design/tilt_isqrt.sv =====
// Pipelined restoring integer square root, one result bit per stage.
module tilt_isqrt
   import tilt_pkg::*;
(
   input  logic    clock,
   input  logic    enable,
   input  sq_type  radicand,
   output mag_type root
);
   localparam int STEPS = SQ_BITS / 2;

   sq_type rem_ff  [STEPS+1];
   sq_type root_ff [STEPS+1];

   assign rem_ff[0]  = radicand;
   assign root_ff[0] = '0;

   // Stage k settles root bit STEPS-1-k; root_ff holds partial root shifted.
   for (genvar k = 0; k < STEPS; k++) begin : g_step
      sq_type rem_r, root_r;
      sq_type trial;
      logic   fits;
      always_comb begin
         trial = {root_ff[k][SQ_BITS-3:0], 2'b01} << (2 * (STEPS - 1 - k));
         fits  = rem_ff[k] >= trial;
      end
      always_ff @(posedge clock) begin
         if (enable) begin
            rem_r  <= fits ? rem_ff[k] - trial : rem_ff[k];
            root_r <= {root_ff[k][SQ_BITS-2:0], fits};
         end
      end
      assign rem_ff[k+1]  = rem_r;
      assign root_ff[k+1] = root_r;
   end

   assign root = root_ff[STEPS][MAG_BITS-1:0];
endmodule

// ===== design/tilt_cordic.sv =====
// Pipelined vectoring CORDIC: angle of (d, n) in degrees, one step per stage.
module tilt_cordic
   import tilt_pkg::*;
#(
   parameter int FRAC = 8
) (
   input  logic           clock,
   input  logic           enable,
   input  mag_type        num,
   input  mag_type        den,
   input  lane_flags_type flags,
   output logic [OUT_BITS-1:0] angle
);
   cw_type  x_ff [CORDIC_STEPS+1];
   cw_type  y_ff [CORDIC_STEPS+1];
   acc_type a_ff [CORDIC_STEPS+1];
   lane_flags_type f_ff [CORDIC_STEPS+1];

   assign x_ff[0] = cw_type'(den);
   assign y_ff[0] = cw_type'(num);
   assign a_ff[0] = '0;
   assign f_ff[0] = flags;

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      cw_type x_r, y_r;
      acc_type a_r;
      lane_flags_type f_r;
      cw_type xs, ys;
      always_comb begin
         xs = x_ff[i] >>> i;
         ys = y_ff[i] >>> i;
      end
      always_ff @(posedge clock) begin
         if (enable) begin
            if (!y_ff[i][CW-1]) begin
               x_r <= x_ff[i] + ys;
               y_r <= y_ff[i] - xs;
               a_r <= a_ff[i] + atan_tab(5'(i));
            end else begin
               x_r <= x_ff[i] - ys;
               y_r <= y_ff[i] + xs;
               a_r <= a_ff[i] - atan_tab(5'(i));
            end
            f_r <= f_ff[i];
         end
      end
      assign x_ff[i+1] = x_r;
      assign y_ff[i+1] = y_r;
      assign a_ff[i+1] = a_r;
      assign f_ff[i+1] = f_r;
   end

   // Clamp, round and sign in one final registered stage.
   localparam acc_type LIM = acc_type'(90) <<< ATAN_FRAC;
   localparam int SH = ATAN_FRAC - FRAC;
   acc_type clamped, rounded, mag_v, signed_v;
   logic [OUT_BITS-1:0] angle_ff;
   lane_flags_type fl;
   always_comb begin
      fl = f_ff[CORDIC_STEPS];
      clamped = a_ff[CORDIC_STEPS];
      if (clamped < 0)   clamped = '0;
      if (clamped > LIM) clamped = LIM;
      rounded = (clamped + (acc_type'(1) <<< (SH - 1))) >>> SH;
      if (fl.num_zero)      mag_v = '0;
      else if (fl.den_zero) mag_v = acc_type'(90) <<< FRAC;
      else                  mag_v = rounded;
      signed_v = fl.neg ? -mag_v : mag_v;
   end
   always_ff @(posedge clock) begin
      if (enable) angle_ff <= signed_v[OUT_BITS-1:0];
   end
   assign angle = angle_ff;
endmodule

// ===== design/tilt_lane.sv =====
// One angle lane: squares, root, CORDIC; root_on_num picks which term is a root.
module tilt_lane
   import tilt_pkg::*;
#(
   parameter int SAMPLE_BITS = 16,
   parameter int FRAC        = 8,
   parameter bit ROOT_ON_NUM = 1'b0
) (
   input  logic                   clock,
   input  logic                   enable,
   input  logic [SAMPLE_BITS-1:0] plain_mag,   // |a|
   input  logic [SAMPLE_BITS-1:0] root_mag_a,  // |b|
   input  logic [SAMPLE_BITS-1:0] root_mag_b,  // |c|
   input  logic                   neg,
   output logic [OUT_BITS-1:0]    angle
);
   localparam int SQ_STEPS = SQ_BITS / 2;

   // Stage 1: squares (at most 24x24 each).
   sq_type sq_a_ff, sq_b_ff;
   mag_type plain_ff;
   lane_flags_type f1_ff;
   always_ff @(posedge clock) begin
      if (enable) begin
         sq_a_ff  <= sq_type'(root_mag_a) * sq_type'(root_mag_a);
         sq_b_ff  <= sq_type'(root_mag_b) * sq_type'(root_mag_b);
         plain_ff <= mag_type'(plain_mag) << GUARD_BITS;
         f1_ff    <= '{neg: neg, num_zero: 1'b0, den_zero: 1'b0};
      end
   end

   // Stage 2: sum and guard shift.
   sq_type sum_ff;
   mag_type plain2_ff;
   lane_flags_type f2_ff;
   always_ff @(posedge clock) begin
      if (enable) begin
         sum_ff    <= (sq_a_ff + sq_b_ff) << (2 * GUARD_BITS);
         plain2_ff <= plain_ff;
         f2_ff     <= f1_ff;
      end
   end

   // Root pipeline with matching delay for the plain term and flags.
   mag_type root_v;
   tilt_isqrt u_sqrt (.clock(clock), .enable(enable), .radicand(sum_ff), .root(root_v));

   mag_type plain_d [SQ_STEPS+1];
   lane_flags_type f_d [SQ_STEPS+1];
   assign plain_d[0] = plain2_ff;
   assign f_d[0]     = f2_ff;
   for (genvar k = 0; k < SQ_STEPS; k++) begin : g_dly
      mag_type p_r;
      lane_flags_type f_r;
      always_ff @(posedge clock) begin
         if (enable) begin
            p_r <= plain_d[k];
            f_r <= f_d[k];
         end
      end
      assign plain_d[k+1] = p_r;
      assign f_d[k+1]     = f_r;
   end

   mag_type num_v, den_v;
   lane_flags_type fl;
   always_comb begin
      num_v = ROOT_ON_NUM ? root_v : plain_d[SQ_STEPS];
      den_v = ROOT_ON_NUM ? plain_d[SQ_STEPS] : root_v;
      fl    = f_d[SQ_STEPS];
      fl.num_zero = (num_v == '0);
      fl.den_zero = (den_v == '0);
   end

   tilt_cordic #(.FRAC(FRAC)) u_cordic (
      .clock(clock), .enable(enable), .num(num_v), .den(den_v),
      .flags(fl), .angle(angle)
   );
endmodule

// ===== bench/tilt_bench_pkg.sv =====
// Payload types for the tilt-angle bench channels.
package tilt_bench_pkg;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [15:0] accel_x;
      logic [15:0] accel_y;
      logic [15:0] accel_z;
   } sample_type;

   typedef struct packed {
      logic [15:0] tilt_x;
      logic [15:0] tilt_y;
      logic [15:0] tilt_z;
      logic        zero_vector;
   } angles_type;
endpackage

// ===== bench/tilt_checker.sv =====
// Watches both channels, predicts the tilt angles and compares them in order.
module tilt_checker
   import tilt_bench_pkg::*;
(
   input  logic clock,
   input  logic reset,
   tilt_if      req_ch,
   tilt_if      rsp_ch,
   output int   fail_count,
   output int   pending,
   output int   checked
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int GUARD = 8;
   localparam int STEPS = 24;
   localparam int AFRAC = 24;
   localparam int OFRAC = 8;

   // atan(2^-i), degrees * 2^24
   localparam longint ATAN_DEG [STEPS] = '{
      754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
      15018523, 7509720, 3754917, 1877466, 938734, 469367,
      234684, 117342, 58671, 29335, 14668, 7334,
      3667, 1833, 917, 458, 229, 115};

   angles_type angle_queue[$];

   function automatic longint int_sqrt(longint v);
      longint rem, root, bit_w;
      rem = v;
      root = 0;
      bit_w = longint'(1) << 62;
      while (bit_w > rem) bit_w = bit_w >> 2;
      while (bit_w != 0) begin
         if (rem >= root + bit_w) begin
            rem = rem - (root + bit_w);
            root = (root >> 1) + bit_w;
         end else begin
            root = root >> 1;
         end
         bit_w = bit_w >> 2;
      end
      return root;
   endfunction

   // atan(n/d) in degrees * 2^8, n and d non-negative
   function automatic longint atan_deg(longint n, longint d);
      longint xr, yr, xs, ys, acc, lim;
      acc = 0;
      if (n == 0) return 0;
      if (d == 0) return longint'(90) << OFRAC;
      xr = d;
      yr = n;
      for (int i = 0; i < STEPS; i++) begin
         xs = xr >>> i;
         ys = yr >>> i;
         if (yr >= 0) begin
            xr = xr + ys; yr = yr - xs; acc = acc + ATAN_DEG[i];
         end else begin
            xr = xr - ys; yr = yr + xs; acc = acc - ATAN_DEG[i];
         end
      end
      lim = longint'(90) << AFRAC;
      if (acc < 0) acc = 0;
      if (acc > lim) acc = lim;
      return (acc + (longint'(1) << (AFRAC - OFRAC - 1))) >> (AFRAC - OFRAC);
   endfunction

   function automatic logic [15:0] signed_angle(longint m, logic neg);
      longint v;
      v = neg ? -m : m;
      return v[15:0];
   endfunction

   function automatic angles_type predict_angles(sample_type s);
      angles_type r;
      longint x, y, z, ax, ay, az;
      x = longint'($signed(s.accel_x));
      y = longint'($signed(s.accel_y));
      z = longint'($signed(s.accel_z));
      ax = x < 0 ? -x : x;
      ay = y < 0 ? -y : y;
      az = z < 0 ? -z : z;
      r = '0;
      if (x == 0 && y == 0 && z == 0) begin
         r.zero_vector = 1'b1;
         return r;
      end
      r.tilt_x = signed_angle(atan_deg(ax << GUARD,
                    int_sqrt((ay*ay + az*az) << (2*GUARD))), x > 0);
      r.tilt_y = signed_angle(atan_deg(ay << GUARD,
                    int_sqrt((ax*ax + az*az) << (2*GUARD))), y < 0);
      r.tilt_z = signed_angle(atan_deg(int_sqrt((ax*ax + ay*ay) << (2*GUARD)),
                    az << GUARD), z < 0);
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      fail_count++;
      $display("mismatch %0s: got %0d want %0d (t=%0t)", what,
               $signed(got), $signed(want), $time);
   endtask

   initial begin
      fail_count = 0;
      checked = 0;
   end

   assign pending = angle_queue.size();

   always @(posedge clock) begin
      angles_type want, got;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            angle_queue.push_back(predict_angles(req_ch.data));
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = rsp_ch.data;
            if (angle_queue.size() == 0) begin
               report_mismatch("unexpected transfer", got.tilt_x, 16'd0);
            end else begin
               want = angle_queue.pop_front();
               checked++;
               if (got.tilt_x !== want.tilt_x)
                  report_mismatch("tilt_x", got.tilt_x, want.tilt_x);
               if (got.tilt_y !== want.tilt_y)
                  report_mismatch("tilt_y", got.tilt_y, want.tilt_y);
               if (got.tilt_z !== want.tilt_z)
                  report_mismatch("tilt_z", got.tilt_z, want.tilt_z);
               if (got.zero_vector !== want.zero_vector)
                  report_mismatch("zero_vector", 16'(got.zero_vector),
                                  16'(want.zero_vector));
            end
         end
      end
   end
endmodule

// ===== bench/accel_tilt_angles_test.sv =====
// Bench top: clock, reset, sample stimulus and the final verdict.
module accel_tilt_angles_test;
   import tilt_bench_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int N_RANDOM    = 1250;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN       = 100;     // pipe is about 61 deep

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic calm  = 1'b0;   // when set, neither side idles
   int   cycles = 0;
   int   fail_count, pending, checked;
   int   n_sent = 0;

   tilt_if #(.T(sample_type)) req_ch (clock);
   tilt_if #(.T(angles_type)) rsp_ch (clock);

   angles_type rsp_word;

   // Flat ports of the block mapped onto the two channels.
   accel_tilt_angles u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_ch.valid),
      .req_ready       (req_ch.ready),
      .req_accel_x     (req_ch.data.accel_x),
      .req_accel_y     (req_ch.data.accel_y),
      .req_accel_z     (req_ch.data.accel_z),
      .rsp_valid       (rsp_ch.valid),
      .rsp_ready       (rsp_ch.ready),
      .rsp_tilt_x      (rsp_word.tilt_x),
      .rsp_tilt_y      (rsp_word.tilt_y),
      .rsp_tilt_z      (rsp_word.tilt_z),
      .rsp_zero_vector (rsp_word.zero_vector)
   );
   assign rsp_ch.data = rsp_word;

   tilt_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .fail_count (fail_count),
      .pending    (pending),
      .checked    (checked)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Watchdog.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("FAIL");
         $finish;
      end
   end

   // Receiver stalls about 18% of the time, never during a calm stretch.
   initial rsp_ch.ready = 1'b0;
   always @(negedge clock)
      rsp_ch.ready <= calm || ($urandom_range(99) >= 18);

   // One sample transfer. Idle gaps come first, then valid is held until accepted.
   // Valid is left high so the next call can reuse it without a drop.
   task automatic send_sample(logic [15:0] x, logic [15:0] y, logic [15:0] z);
      @(negedge clock);
      while (!calm && $urandom_range(99) < 18) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data  <= '{accel_x: x, accel_y: y, accel_z: z};
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      n_sent++;
   endtask

   // Random component: full range, small magnitudes, zero, or an extreme.
   function automatic logic [15:0] rand_axis();
      int pick;
      pick = $urandom_range(9);
      if (pick < 5) return 16'($urandom);
      if (pick < 8) return 16'($signed($urandom_range(64)) - 32);
      if (pick < 9) return 16'd0;
      return $urandom_range(1) ? 16'h7fff : 16'h8000;
   endfunction

   initial begin
      req_ch.valid = 1'b0;
      req_ch.data  = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: all-zero vector, extremes, zero numerators and zero denominators.
      send_sample(16'h0000, 16'h0000, 16'h0000);
      send_sample(16'h8000, 16'h8000, 16'h8000);
      send_sample(16'h7fff, 16'h7fff, 16'h7fff);
      send_sample(16'h7fff, 16'h8000, 16'h7fff);
      send_sample(16'h0001, 16'h0000, 16'h0000);   // x only: x at -90, z den 0
      send_sample(16'hffff, 16'h0000, 16'h0000);   // x only, negative
      send_sample(16'h0000, 16'h0005, 16'h0000);   // y only: z=0 counts positive
      send_sample(16'h0000, 16'h8000, 16'h0000);
      send_sample(16'h0000, 16'h0000, 16'h4000);   // flat: x,y zero numerators
      send_sample(16'h0000, 16'h0000, 16'hc000);   // upside down
      send_sample(16'h8000, 16'h0000, 16'h0000);
      send_sample(16'h7fff, 16'h0000, 16'h0000);
      send_sample(16'h0001, 16'h0001, 16'h0001);
      send_sample(16'hffff, 16'hffff, 16'hffff);
      send_sample(16'h1000, 16'hf000, 16'h0000);
      send_sample(16'h0000, 16'h7fff, 16'h8000);
      send_sample(16'h8000, 16'h7fff, 16'h0001);
      send_sample(16'h5555, 16'haaaa, 16'h5555);
      send_sample(16'haaaa, 16'h5555, 16'haaaa);

      // Random, with a calm stretch in the middle to run the pipe at full rate.
      for (int i = 0; i < N_RANDOM; i++) begin
         calm = (i >= 500 && i < 650);
         send_sample(rand_axis(), rand_axis(), rand_axis());
      end
      calm = 1'b0;
      @(negedge clock);
      req_ch.valid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);

      $display("sent %0d samples, checked %0d angle sets", n_sent, checked);
      $display("covered extremes, zero vector, zero denominators and random stalls");
      if (fail_count == 0 && pending == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end
endmodule
